// File: rtl/utja_pkg.sv
package utja_pkg;

  localparam int MAX_VARS = 8;
  localparam int DOMAIN_BITS = 8;
  localparam int UTIL_WIDTH = 32;
  localparam int IDX_W = 24;
  localparam int CNT_W = 4;
  localparam int POS_W = 3;
  localparam int ACC_W = 64;
  localparam int CFG_W = 64;
  localparam int DOMS_W = MAX_VARS * DOMAIN_BITS;
  localparam int MAP_W = MAX_VARS * POS_W;
  localparam int STEP_BITS = 4;
  localparam int SOURCE_DEPTH_DEF = 4096;

  localparam logic [1:0] REG_TARGET_CNT = 2'd0;
  localparam logic [1:0] REG_SOURCE_CNT = 2'd1;
  localparam logic [1:0] REG_TARGET_DOMS = 2'd2;
  localparam logic [1:0] REG_SOURCE_MAP = 2'd3;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_JOIN = 1'b1;

  localparam logic ST_OK = 1'b0;
  localparam logic ST_RANGE = 1'b1;

  typedef struct packed {
    logic                  op;
    logic [IDX_W-1:0]      index;
    logic [UTIL_WIDTH-1:0] value;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0]  tn;
    logic [CNT_W-1:0]  sn;
    logic [DOMS_W-1:0] doms;
    logic [MAP_W-1:0]  map;
  } cfg_t;

  typedef struct packed {
    item_t                  item;
    logic [DOMS_W-1:0]      digits;
    logic [DOMAIN_BITS-1:0] tmod;
    logic [IDX_W-1:0]       num;
  } stage_t;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    if (c == '0) begin
      r = CNT_W'(1);
    end else if (c > CNT_W'(MAX_VARS)) begin
      r = CNT_W'(MAX_VARS);
    end else begin
      r = c;
    end
    return r;
  endfunction

  function automatic logic [DOMAIN_BITS-1:0] dom_at(input logic [DOMS_W-1:0] v,
                                                    input logic [POS_W-1:0] pos);
    return v[pos*DOMAIN_BITS +: DOMAIN_BITS];
  endfunction

  function automatic logic [POS_W-1:0] pos_of(input logic [MAP_W-1:0] m,
                                              input logic [POS_W-1:0] k);
    return m[k*POS_W +: POS_W];
  endfunction

endpackage

// File: rtl/utja_ram.sv
module utja_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/utja_div.sv
module utja_div
  import utja_pkg::*;
#(
  parameter int N_W = IDX_W,
  parameter int D_W = DOMAIN_BITS,
  parameter int PAY_W = 1,
  parameter int STEP = STEP_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             vin,
  input  logic [N_W-1:0]   num_in,
  input  logic [D_W-1:0]   den_in,
  input  logic [PAY_W-1:0] pay_in,
  output logic             vout,
  output logic [N_W-1:0]   quo,
  output logic [D_W-1:0]   rem,
  output logic [PAY_W-1:0] pay_out
);

  localparam int ST = (N_W + STEP - 1) / STEP;
  localparam int NP = ST * STEP;

  logic             v_s [0:ST];
  logic [NP-1:0]    n_s [0:ST];
  logic [NP-1:0]    q_s [0:ST];
  logic [D_W-1:0]   r_s [0:ST];
  logic [D_W-1:0]   d_s [0:ST];
  logic [PAY_W-1:0] p_s [0:ST];

  assign v_s[0] = vin;
  assign n_s[0] = NP'(num_in);
  assign q_s[0] = '0;
  assign r_s[0] = '0;
  assign d_s[0] = den_in;
  assign p_s[0] = pay_in;

  for (genvar s = 0; s < ST; s++) begin : g_stage
    logic [NP-1:0]  n_next;
    logic [NP-1:0]  q_next;
    logic [D_W-1:0] r_next;

    always_comb begin
      logic [D_W:0] tmp;
      logic         ge;
      n_next = n_s[s];
      q_next = q_s[s];
      r_next = r_s[s];
      for (int b = 0; b < STEP; b++) begin
        tmp = {r_next, n_next[NP-1]};
        n_next = {n_next[NP-2:0], 1'b0};
        ge = (tmp >= {1'b0, d_s[s]});
        if (ge) begin
          r_next = D_W'(tmp - {1'b0, d_s[s]});
        end else begin
          r_next = tmp[D_W-1:0];
        end
        q_next = {q_next[NP-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[s+1] <= 1'b0;
      end else begin
        v_s[s+1] <= v_s[s];
      end
      n_s[s+1] <= n_next;
      q_s[s+1] <= q_next;
      r_s[s+1] <= r_next;
      d_s[s+1] <= d_s[s];
      p_s[s+1] <= p_s[s];
    end
  end

  assign vout = v_s[ST];
  assign quo = (d_s[ST] == '0) ? '0 : q_s[ST][N_W-1:0];
  assign rem = (d_s[ST] == '0) ? '0 : r_s[ST];
  assign pay_out = p_s[ST];

endmodule

// File: rtl/utja_digits.sv
module utja_digits
  import utja_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  logic                   in_valid,
  input  item_t                  in_item,
  output logic                   out_valid,
  output item_t                  out_item,
  output logic [DOMS_W-1:0]      out_digits,
  output logic [DOMAIN_BITS-1:0] out_tmod
);

  logic                   sv [0:MAX_VARS];
  stage_t                 sp [0:MAX_VARS];
  logic [DOMAIN_BITS-1:0] lane_rem;

  assign sv[0] = in_valid;
  assign sp[0] = '{item: in_item, digits: '0, tmod: '0, num: in_item.index};

  utja_div #(.PAY_W(1)) u_lane (
    .clk(clk),
    .rst(rst),
    .vin(in_valid),
    .num_in(in_item.index),
    .den_in(dom_at(cfg.doms, pos_of(cfg.map, POS_W'(cfg.sn - CNT_W'(1))))),
    .pay_in(1'b0),
    .vout(),
    .quo(),
    .rem(lane_rem),
    .pay_out()
  );

  for (genvar i = 0; i < MAX_VARS; i++) begin : g_pos
    localparam int P = MAX_VARS - 1 - i;
    logic                   dv;
    logic [IDX_W-1:0]       dq;
    logic [DOMAIN_BITS-1:0] dr;
    stage_t                 dp;

    utja_div #(.PAY_W($bits(stage_t))) u_div (
      .clk(clk),
      .rst(rst),
      .vin(sv[i]),
      .num_in(sp[i].num),
      .den_in(dom_at(cfg.doms, POS_W'(P))),
      .pay_in(sp[i]),
      .vout(dv),
      .quo(dq),
      .rem(dr),
      .pay_out(dp)
    );

    always_comb begin
      sp[i+1] = dp;
      sp[i+1].digits[P*DOMAIN_BITS +: DOMAIN_BITS] = dr;
      if (i == 0) begin
        sp[i+1].tmod = lane_rem;
      end
      if (CNT_W'(P) < cfg.tn) begin
        sp[i+1].num = dq;
      end
    end
    assign sv[i+1] = dv;
  end

  assign out_valid = sv[MAX_VARS];
  assign out_item = sp[MAX_VARS].item;
  assign out_digits = sp[MAX_VARS].digits;
  assign out_tmod = sp[MAX_VARS].tmod;

endmodule

// File: rtl/utja_horner.sv
module utja_horner
  import utja_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  logic                   in_valid,
  input  item_t                  in_item,
  input  logic [DOMS_W-1:0]      in_digits,
  input  logic [DOMAIN_BITS-1:0] in_tmod,
  output logic                   out_valid,
  output item_t                  out_item,
  output logic [ACC_W-1:0]       out_index
);

  logic                   hv  [0:MAX_VARS-1];
  item_t                  hit [0:MAX_VARS-1];
  logic [ACC_W-1:0]       hacc[0:MAX_VARS-1];
  logic [DOMS_W-1:0]      hdig[0:MAX_VARS-1];
  logic [DOMAIN_BITS-1:0] htm [0:MAX_VARS-1];

  assign hv[0] = in_valid;
  assign hit[0] = in_item;
  assign hdig[0] = in_digits;
  assign htm[0] = in_tmod;
  assign hacc[0] = (cfg.sn == CNT_W'(1)) ? ACC_W'(in_tmod)
                 : ACC_W'(dom_at(in_digits, pos_of(cfg.map, POS_W'(0))));

  for (genvar k = 1; k < MAX_VARS; k++) begin : g_step
    logic [ACC_W-1:0] acc_next;

    always_comb begin
      logic [DOMAIN_BITS-1:0] sd;
      logic [DOMAIN_BITS-1:0] dg;
      logic [ACC_W-1:0]       prod;
      sd = dom_at(cfg.doms, pos_of(cfg.map, POS_W'(k)));
      if (CNT_W'(k) == cfg.sn - CNT_W'(1)) begin
        dg = htm[k-1];
      end else begin
        dg = dom_at(hdig[k-1], pos_of(cfg.map, POS_W'(k)));
      end
      prod = hacc[k-1] * ACC_W'(sd);
      if (CNT_W'(k) < cfg.sn) begin
        acc_next = prod + ACC_W'(dg);
      end else begin
        acc_next = hacc[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        hv[k] <= 1'b0;
      end else begin
        hv[k] <= hv[k-1];
      end
      hit[k] <= hit[k-1];
      hacc[k] <= acc_next;
      hdig[k] <= hdig[k-1];
      htm[k] <= htm[k-1];
    end
  end

  assign out_valid = hv[MAX_VARS-1];
  assign out_item = hit[MAX_VARS-1];
  assign out_index = hacc[MAX_VARS-1];

endmodule

// File: rtl/utility_table_join_accumulate.sv
// Channel   Signals                                   Direction
// item      start, busy, opcode, entry_index,         in (busy out)
//           entry_value
// result    done, result_value, source_index, status  out
// config    cfg_we, cfg_addr, cfg_data                in
//
// One beat is taken in every cycle; busy stays low.
// A beat passes through the input register, the chain of eight six-stage digit
// dividers, the seven-stage index multiply chain, the source table read and the
// output register before its result appears.
// Reset clears the valid bits and resets the configuration; the table is not cleared.
// The result side cannot stall, so nothing in the pipeline ever waits.
module utility_table_join_accumulate
  import utja_pkg::*;
#(
  parameter int SOURCE_DEPTH = SOURCE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  opcode,
  input  logic [IDX_W-1:0]      entry_index,
  input  logic [UTIL_WIDTH-1:0] entry_value,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_addr,
  input  logic [CFG_W-1:0]      cfg_data,
  output logic                  done,
  output logic [UTIL_WIDTH-1:0] result_value,
  output logic [IDX_W-1:0]      source_index,
  output logic                  status
);

  localparam int AW = $clog2(SOURCE_DEPTH);
  localparam int DIV_ST = (IDX_W + STEP_BITS - 1) / STEP_BITS;
  localparam int LAT = MAX_VARS * DIV_ST + MAX_VARS + 2;

  logic [CNT_W-1:0]  target_var_count;
  logic [CNT_W-1:0]  source_var_count;
  logic [DOMS_W-1:0] target_domain_sizes;
  logic [MAP_W-1:0]  source_to_target_map;
  cfg_t              cfg;

  logic                   v0;
  item_t                  item0;
  logic                   dg_v;
  item_t                  dg_item;
  logic [DOMS_W-1:0]      dg_digits;
  logic [DOMAIN_BITS-1:0] dg_tmod;
  logic                   hn_v;
  item_t                  hn_item;
  logic [ACC_W-1:0]       hn_index;

  logic                   hn_range;
  logic                   vm;
  item_t                  itm;
  logic [IDX_W-1:0]       idxm;
  logic                   rangem;
  logic [UTIL_WIDTH-1:0]  rdata;
  logic                   ram_we;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_var_count <= CNT_W'(1);
      source_var_count <= CNT_W'(1);
      target_domain_sizes <= {MAX_VARS{DOMAIN_BITS'(1)}};
      source_to_target_map <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_TARGET_CNT:  target_var_count <= cfg_data[CNT_W-1:0];
        REG_SOURCE_CNT:  source_var_count <= cfg_data[CNT_W-1:0];
        REG_TARGET_DOMS: target_domain_sizes <= cfg_data[DOMS_W-1:0];
        REG_SOURCE_MAP:  source_to_target_map <= cfg_data[MAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = '{tn: clamp_count(target_var_count), sn: clamp_count(source_var_count),
                 doms: target_domain_sizes, map: source_to_target_map};

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
    item0 <= '{op: opcode, index: entry_index, value: entry_value};
  end

  utja_digits u_digits (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .in_valid(v0),
    .in_item(item0),
    .out_valid(dg_v),
    .out_item(dg_item),
    .out_digits(dg_digits),
    .out_tmod(dg_tmod)
  );

  utja_horner u_horner (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .in_valid(dg_v),
    .in_item(dg_item),
    .in_digits(dg_digits),
    .in_tmod(dg_tmod),
    .out_valid(hn_v),
    .out_item(hn_item),
    .out_index(hn_index)
  );

  always_comb begin
    if (hn_item.op == OP_LOAD) begin
      hn_range = (ACC_W'(hn_item.index) < ACC_W'(SOURCE_DEPTH));
    end else begin
      hn_range = (hn_index < ACC_W'(SOURCE_DEPTH));
    end
  end

  assign ram_we = hn_v && (hn_item.op == OP_LOAD) && hn_range;

  utja_ram #(.WIDTH(UTIL_WIDTH), .DEPTH(SOURCE_DEPTH)) u_table (
    .clk(clk),
    .we(ram_we),
    .waddr(hn_item.index[AW-1:0]),
    .wdata(hn_item.value),
    .raddr(hn_index[AW-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else begin
      vm <= hn_v;
    end
    itm <= hn_item;
    idxm <= (hn_item.op == OP_LOAD) ? hn_item.index : hn_index[IDX_W-1:0];
    rangem <= hn_range;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vm;
    end
    source_index <= idxm;
    status <= rangem ? ST_OK : ST_RANGE;
    if (itm.op == OP_LOAD) begin
      result_value <= '0;
    end else if (rangem) begin
      result_value <= itm.value + rdata;
    end else begin
      result_value <= itm.value;
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done == $past(start && !busy && !rst, LAT))
    else $error("result strobe does not follow its beat");

  a_ok_in_range: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_OK) |-> (ACC_W'(source_index) < ACC_W'(SOURCE_DEPTH)))
    else $error("ok status with index beyond the table");

  a_load_zero: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (hn_item.op == OP_LOAD) && hn_range)
    else $error("table write outside a valid load");

endmodule

// File: verif/tb_utility_table_join_accumulate.sv
`timescale 1ns / 100ps

module tb_utility_table_join_accumulate;
  import utja_pkg::*;

  localparam int DEPTH = 4096;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [UTIL_WIDTH-1:0] value;
    logic [IDX_W-1:0]      sidx;
    logic                  st;
  } join_result_t;

  class join_scoreboard;
    logic [CNT_W-1:0]      tn_r;
    logic [CNT_W-1:0]      sn_r;
    logic [DOMS_W-1:0]     doms_r;
    logic [MAP_W-1:0]      map_r;
    logic [UTIL_WIDTH-1:0] utility[DEPTH];
    bit                    written[DEPTH];
    join_result_t          pending[$];
    int                    errors;
    int                    checked;

    function new();
      tn_r = 1;
      sn_r = 1;
      doms_r = 64'h0101010101010101;
      map_r = '0;
      errors = 0;
      checked = 0;
    endfunction

    function int unsigned clampn(logic [CNT_W-1:0] c);
      if (c == 0) return 1;
      if (c > MAX_VARS) return MAX_VARS;
      return c;
    endfunction

    function longint unsigned dom(int unsigned pos);
      return doms_r[pos*DOMAIN_BITS +: DOMAIN_BITS];
    endfunction

    function int unsigned mpos(int unsigned k);
      return map_r[k*POS_W +: POS_W];
    endfunction

    function longint unsigned project(logic [IDX_W-1:0] t);
      int unsigned tn;
      int unsigned sn;
      longint unsigned sdom[MAX_VARS];
      longint unsigned idx;
      longint unsigned mult;
      longint unsigned dv;
      longint unsigned q;
      longint unsigned digit;
      tn = clampn(tn_r);
      sn = clampn(sn_r);
      idx = 0;
      for (int k = 0; k < sn; k++) sdom[k] = dom(mpos(k));
      for (int k = 0; k + 1 < sn; k++) begin
        mult = 1;
        dv = 1;
        for (int j = k + 1; j < sn; j++) mult = mult * sdom[j];
        for (int j = mpos(k) + 1; j < tn && j < MAX_VARS; j++) dv = dv * dom(j);
        q = (dv != 0) ? longint'(t) / dv : 0;
        digit = (sdom[k] != 0) ? q % sdom[k] : 0;
        idx = idx + mult * digit;
      end
      if (sdom[sn-1] != 0) idx = idx + longint'(t) % sdom[sn-1];
      return idx;
    endfunction

    function void set_reg(logic [1:0] a, logic [CFG_W-1:0] d);
      case (a)
        REG_TARGET_CNT:  tn_r = d[CNT_W-1:0];
        REG_SOURCE_CNT:  sn_r = d[CNT_W-1:0];
        REG_TARGET_DOMS: doms_r = d[DOMS_W-1:0];
        REG_SOURCE_MAP:  map_r = d[MAP_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_beat(logic op, logic [IDX_W-1:0] ix, logic [UTIL_WIDTH-1:0] v);
      join_result_t r;
      longint unsigned s;
      if (op == OP_LOAD) begin
        r.value = '0;
        r.sidx = ix;
        if (ix < DEPTH) begin
          utility[ix] = v;
          written[ix] = 1;
          r.st = ST_OK;
        end else begin
          r.st = ST_RANGE;
        end
      end else begin
        s = project(ix);
        r.sidx = s[IDX_W-1:0];
        if (s < DEPTH) begin
          r.value = v + utility[s];
          r.st = ST_OK;
        end else begin
          r.value = v;
          r.st = ST_RANGE;
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [UTIL_WIDTH-1:0] v, logic [IDX_W-1:0] si, logic st);
      join_result_t e;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: value %h index %h status %b", v, si, st);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (v !== e.value) begin
        $error("result_value expected %h actual %h", e.value, v);
        errors++;
      end
      if (si !== e.sidx) begin
        $error("source_index expected %h actual %h", e.sidx, si);
        errors++;
      end
      if (st !== e.st) begin
        $error("status expected %b actual %b", e.st, st);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic                  opcode;
  logic [IDX_W-1:0]      entry_index;
  logic [UTIL_WIDTH-1:0] entry_value;
  logic                  cfg_we;
  logic [1:0]            cfg_addr;
  logic [CFG_W-1:0]      cfg_data;
  logic                  done;
  logic [UTIL_WIDTH-1:0] result_value;
  logic [IDX_W-1:0]      source_index;
  logic                  status;

  join_scoreboard sb;
  int  cycles = 0;
  bit  no_gaps = 0;
  int  beats = 0;

  utility_table_join_accumulate DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .entry_index(entry_index), .entry_value(entry_value), .cfg_we(cfg_we),
    .cfg_addr(cfg_addr), .cfg_data(cfg_data), .done(done),
    .result_value(result_value), .source_index(source_index), .status(status)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[utility_table_join_accumulate] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result_value, source_index, status);
  end

  function automatic logic [UTIL_WIDTH-1:0] rand_utility();
    case ($urandom_range(0, 9))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'hffffffff;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_beat(logic op, logic [IDX_W-1:0] ix, logic [UTIL_WIDTH-1:0] v);
    while (!no_gaps && $urandom_range(0, 99) < 21) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    entry_index <= ix;
    entry_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_beat(op, ix, v);
    beats++;
  endtask

  // A join whose source entry was never written becomes a load of that entry.
  task automatic send_safe_join(logic [IDX_W-1:0] t, logic [UTIL_WIDTH-1:0] v);
    longint unsigned s;
    s = sb.project(t);
    if (s < DEPTH && !sb.written[s]) send_beat(OP_LOAD, s[IDX_W-1:0], rand_utility());
    else send_beat(OP_JOIN, t, v);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] a, logic [CFG_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_addr <= a;
    cfg_data <= d;
    @(posedge clk);
    sb.set_reg(a, d);
  endtask

  task automatic configure(logic [3:0] tn, logic [3:0] sn, logic [63:0] d, logic [23:0] m);
    write_reg(REG_TARGET_CNT, {60'h0, tn});
    write_reg(REG_SOURCE_CNT, {60'h0, sn});
    write_reg(REG_TARGET_DOMS, d);
    write_reg(REG_SOURCE_MAP, {40'h0, m});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [63:0] d;
    logic [IDX_W-1:0] t;
    int span;
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    opcode = OP_LOAD;
    entry_index = '0;
    entry_value = '0;
    cfg_we = 1'b0;
    cfg_addr = REG_TARGET_CNT;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset configuration: every position projects to entry zero.
    send_beat(OP_LOAD, IDX_W'(0), 32'h7fffffff);
    send_beat(OP_JOIN, 24'hffffff, 32'h00000001);
    send_beat(OP_LOAD, 24'hffffff, 32'h12345678);
    send_beat(OP_LOAD, IDX_W'(DEPTH), 32'h80000000);
    send_beat(OP_LOAD, IDX_W'(DEPTH - 1), 32'h80000000);
    drain();

    configure(4'd3, 4'd2, 64'h0000000000050304, 24'o20);
    for (int i = 0; i < 20; i++) send_beat(OP_LOAD, IDX_W'(i), rand_utility());
    send_beat(OP_JOIN, IDX_W'(0), 32'h80000000);
    send_beat(OP_JOIN, IDX_W'(59), 32'hffffffff);
    send_beat(OP_JOIN, 24'hffffff, 32'h7fffffff);
    drain();

    // Large domains and clamped counts; with eight source variables the projection lands beyond the store.
    configure(4'd15, 4'd0, 64'hffffffffffffffff, 24'hffffff);
    send_beat(OP_JOIN, 24'hffffff, 32'h80000000);
    send_safe_join(24'h000fff, 32'h1);
    drain();
    configure(4'd8, 4'd8, 64'hffffffffffffffff, 24'o76543210);
    send_beat(OP_JOIN, 24'h800000, 32'h7fffffff);
    drain();

    // Zero domain sizes and mapped positions beyond the target count.
    configure(4'd0, 4'd15, 64'h0, 24'h0);
    send_safe_join(24'h123456, 32'hdeadbeef);
    drain();
    configure(4'd2, 4'd3, 64'h0000000000000300, 24'o765);
    send_safe_join(24'hfedcba, 32'h00000005);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      no_gaps = (ph == 3);
      d = {$urandom(), $urandom()};
      for (int b = 0; b < 8; b++) begin
        case ($urandom_range(0, 5))
          0: d[b*8 +: 8] = 8'h00;
          1, 2, 3: d[b*8 +: 8] = 8'($urandom_range(1, 6));
          default: ;
        endcase
      end
      configure(($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                            : 4'($urandom_range(1, 8)),
                ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                            : 4'($urandom_range(1, 8)),
                d, 24'($urandom()));
      span = $urandom_range(8, 256);
      for (int i = 0; i < 40; i++) begin
        if ($urandom_range(0, 9) == 0) send_beat(OP_LOAD, 24'($urandom()), rand_utility());
        else send_beat(OP_LOAD, IDX_W'($urandom_range(0, span - 1)), rand_utility());
      end
      for (int i = 0; i < 150; i++) begin
        t = ($urandom_range(0, 3) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 4095));
        if ($urandom_range(0, 9) == 0) send_beat(OP_LOAD,
                                                 IDX_W'($urandom_range(0, span - 1)),
                                                 rand_utility());
        else send_safe_join(t, rand_utility());
      end
      drain();
    end

    $display("Sent %0d item beats over fourteen configurations; %0d results checked.",
             beats, sb.checked);
    $display("Loads, joins, out-of-store indices, zero domains and clamped counts seen.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[utility_table_join_accumulate] OK");
    end else begin
      $display("[utility_table_join_accumulate] ERROR");
    end
    $finish;
  end

endmodule
